>>> src/positional_array_list_top_macros.svh
// assertion macros for the positional array list
// used by positional_array_list_top; expects clk and rst_n in scope
`ifndef POSITIONAL_ARRAY_LIST_TOP_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define PAL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked on the following edge
`define PAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/pal_pkg.sv
// shared types and codes for the positional array list
// no dependencies
package pal_pkg;

    localparam int CAPACITY    = 32;
    localparam int OP_W        = 2;
    localparam int POS_W       = 6;
    localparam int VAL_W       = 32;
    localparam int STAT_W      = 2;
    localparam int CNT_OUT_W   = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;
    localparam logic [OP_W-1:0] OP_READ   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

    // one classified item as it travels from front to back
    typedef struct packed {
        logic [OP_W-1:0]        op;
        logic [POS_W-1:0]       idx;
        logic signed [VAL_W-1:0] value;
        logic [STAT_W-1:0]      status;
        logic [CNT_OUT_W-1:0]   count_after;
    } cmd_t;

    // queue status seen by front and back
    typedef struct packed {
        logic empty;
        logic full;
    } queue_flags_t;

endpackage

>>> src/positional_array_list_top.sv
// top level of the positional array list: front, queue, back
// depends on pal_pkg, pal_front, pal_queue, pal_back and the macros header
//
// Packed list of up to CAPACITY signed 32-bit words with 1-based positions.
// An item (operation, position, value) is taken at a rising edge with start
// high and busy low. Operations: insert at 1..count+1 shifting later entries
// up, delete at 1..count shifting later entries down and returning the
// removed word, update in place, and read. A bad position gives status 1,
// an insert into a full list gives status 2, and either leaves the list
// untouched; data_out is zero unless a delete or read succeeds. Exactly one
// result per item appears on status/data_out/count_out with done high for
// one cycle; the item is held in the queue and then in the result register before
// done rises. There is no way to hold it off, so sample it on that cycle.
// The block takes one item every cycle: the front checks the position
// against its own entry count in the cycle of acceptance, the back moves
// every cell toward or away from its neighbor all at once, and the back
// drains the queue one item per cycle, so the queue never holds more than
// one item and busy never rises. Entry contents are not cleared at reset;
// only positions already written are ever returned.
`include "positional_array_list_top_macros.svh"

module positional_array_list_top #(
    parameter int CAPACITY = pal_pkg::CAPACITY
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [pal_pkg::OP_W-1:0]          operation,
    input  logic [pal_pkg::POS_W-1:0]         position,
    input  logic signed [pal_pkg::VAL_W-1:0]  value,
    output logic                              done,
    output logic [pal_pkg::STAT_W-1:0]        status,
    output logic signed [pal_pkg::VAL_W-1:0]  data_out,
    output logic [pal_pkg::CNT_OUT_W-1:0]     count_out
);

    // item taken this cycle
    logic                  accept;
    // classified item from the front
    pal_pkg::cmd_t         front_cmd;
    // oldest item waiting for the back
    pal_pkg::cmd_t         head_cmd;
    pal_pkg::queue_flags_t qflags;
    // back works whenever something is queued
    logic                  exec;

    assign busy   = qflags.full;
    assign accept = start && !busy;
    assign exec   = !qflags.empty;

    // front: range and fill checks, entry count bookkeeping
    pal_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (operation),
        .position  (position),
        .value     (value),
        .cmd       (front_cmd)
    );

    // decoupling queue
    pal_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_cmd (front_cmd),
        .pop      (exec),
        .head_cmd (head_cmd),
        .flags    (qflags)
    );

    // back: cell row and result register
    pal_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .exec      (exec),
        .cmd       (head_cmd),
        .done      (done),
        .status    (status),
        .data_out  (data_out),
        .count_out (count_out)
    );

    // every taken item is later reported with done high
    `PAL_ASSERT_NEXT(a_item_result, accept, ##1 done, "accepted item produced no result")
    // failed items never return data
    `PAL_ASSERT_NOW(a_fail_zero, done && status != pal_pkg::ST_OK, data_out == '0,
        "failed item returned nonzero data")
    // a full report means the count did not move off capacity
    `PAL_ASSERT_NOW(a_full_count, done && status == pal_pkg::ST_FULL,
        count_out == pal_pkg::CNT_OUT_W'(CAPACITY), "full status with count below capacity")
    // the queue never holds more than the back can drain
    `PAL_ASSERT_NOW(a_no_backlog, !qflags.empty, exec, "queued item not executed")

endmodule

>>> src/pal_front.sv
// front end: checks position and fill level, tracks the entry count
// depends on pal_pkg
module pal_front #(
    parameter int CAPACITY = pal_pkg::CAPACITY
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic [pal_pkg::OP_W-1:0]           operation,
    input  logic [pal_pkg::POS_W-1:0]          position,
    input  logic signed [pal_pkg::VAL_W-1:0]   value,
    output pal_pkg::cmd_t                      cmd
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int POSW  = pal_pkg::POS_W;
    localparam int CMP_W = ((CNT_W > POSW) ? CNT_W : POSW) + 1;
    localparam int COW   = pal_pkg::CNT_OUT_W;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [pal_pkg::STAT_W-1:0] status;

    assign pos_ext = CMP_W'(position);
    assign cnt_ext = CMP_W'(count_reg);

    always_comb
    begin
        status     = pal_pkg::ST_OK;
        count_next = count_reg;
        if (operation == pal_pkg::OP_INSERT)
        begin
            if (position == '0 || pos_ext > cnt_ext + CMP_W'(1))
                status = pal_pkg::ST_BADPOS;
            else if (cnt_ext == CMP_W'(CAPACITY))
                status = pal_pkg::ST_FULL;
            else
                count_next = count_reg + CNT_W'(1);
        end
        else
        begin
            if (position == '0 || pos_ext > cnt_ext)
                status = pal_pkg::ST_BADPOS;
            else if (operation == pal_pkg::OP_DELETE)
                count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        cmd.op          = operation;
        cmd.idx         = position - POSW'(1);
        cmd.value       = value;
        cmd.status      = status;
        cmd.count_after = COW'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (accept)
            count_reg <= count_next;
    end

endmodule

>>> src/pal_queue.sv
// short command queue between front and back
// depends on pal_pkg
module pal_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  pal_pkg::cmd_t         push_cmd,
    input  logic                  pop,
    output pal_pkg::cmd_t         head_cmd,
    output pal_pkg::queue_flags_t flags
);

    localparam int DEPTH = pal_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    pal_pkg::cmd_t slots [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              do_push;
    logic              do_pop;

    assign flags.empty = (fill_reg == '0);
    assign flags.full  = (fill_reg == FILL_W'(DEPTH));
    assign do_push     = push && !flags.full;
    assign do_pop      = pop && !flags.empty;
    assign head_cmd    = slots[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                fill_reg <= fill_reg + FILL_W'(1);
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - FILL_W'(1);
        end
    end

endmodule

>>> src/pal_back.sv
// back end: row of shifting entry cells and the result register
// depends on pal_pkg
module pal_back #(
    parameter int CAPACITY = pal_pkg::CAPACITY
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              exec,
    input  pal_pkg::cmd_t                     cmd,
    output logic                              done,
    output logic [pal_pkg::STAT_W-1:0]        status,
    output logic signed [pal_pkg::VAL_W-1:0]  data_out,
    output logic [pal_pkg::CNT_OUT_W-1:0]     count_out
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic signed [pal_pkg::VAL_W-1:0] cells      [CAPACITY];
    logic signed [pal_pkg::VAL_W-1:0] cells_next [CAPACITY];
    logic                             apply;
    logic [IW-1:0]                    rd_idx;
    logic signed [pal_pkg::VAL_W-1:0] data_next;

    logic                             done_reg;
    logic [pal_pkg::STAT_W-1:0]       status_reg;
    logic signed [pal_pkg::VAL_W-1:0] data_reg;
    logic [pal_pkg::CNT_OUT_W-1:0]    count_reg;

    assign apply  = exec && (cmd.status == pal_pkg::ST_OK);
    assign rd_idx = IW'(cmd.idx);

    always_comb
    begin
        data_next = '0;
        if (apply && (cmd.op == pal_pkg::OP_DELETE || cmd.op == pal_pkg::OP_READ))
            data_next = cells[rd_idx];
    end

    // each cell picks its own value, its lower neighbor's or its upper neighbor's
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        localparam int PREV = (g > 0) ? g - 1 : 0;
        localparam int NXT  = (g < CAPACITY - 1) ? g + 1 : g;

        always_comb
        begin
            cells_next[g] = cells[g];
            if (apply)
            begin
                unique case (cmd.op)
                    pal_pkg::OP_INSERT:
                    begin
                        if (int'(cmd.idx) == g)
                            cells_next[g] = cmd.value;
                        else if (int'(cmd.idx) < g)
                            cells_next[g] = cells[PREV];
                    end
                    pal_pkg::OP_DELETE:
                    begin
                        if (int'(cmd.idx) <= g)
                            cells_next[g] = cells[NXT];
                    end
                    pal_pkg::OP_UPDATE:
                    begin
                        if (int'(cmd.idx) == g)
                            cells_next[g] = cmd.value;
                    end
                    default:
                    begin
                        cells_next[g] = cells[g];
                    end
                endcase
            end
        end

        always_ff @(posedge clk)
        begin
            cells[g] <= cells_next[g];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= exec;
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            status_reg <= cmd.status;
            data_reg   <= data_next;
            count_reg  <= cmd.count_after;
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign data_out  = data_reg;
    assign count_out = count_reg;

endmodule

>>> dv/tb_positional_array_list_top.sv
// testbench for positional_array_list_top: directed and random list operations
// checked against an in-bench list predictor; depends on pal_pkg and the block rtl
`timescale 1ns / 100ps

module tb_positional_array_list_top;

    localparam int CLK_HALF    = 5;
    localparam int RESET_CYC   = 5;
    localparam int N_RANDOM    = 1000;
    localparam int TAIL_CYC    = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_LIMIT = 50;

    // one pending item, or a marker that holds the sender until all results are back
    typedef struct {
        logic [pal_pkg::OP_W-1:0]          op;
        logic [pal_pkg::POS_W-1:0]         pos;
        logic signed [pal_pkg::VAL_W-1:0]  value;
        bit                                drain;
        int                                idle_pct;
    } list_op_t;

    // one predicted result
    typedef struct {
        logic [pal_pkg::STAT_W-1:0]        status;
        logic signed [pal_pkg::VAL_W-1:0]  data;
        logic [pal_pkg::CNT_OUT_W-1:0]     count;
    } list_resp_t;

    // contents and length of the packed list
    typedef struct {
        logic signed [pal_pkg::VAL_W-1:0]  words [pal_pkg::CAPACITY];
        int                                len;
    } list_state_t;

    logic                                  clk       = 1'b0;
    logic                                  rst_n     = 1'b0;
    logic                                  start     = 1'b0;
    logic [pal_pkg::OP_W-1:0]              operation = '0;
    logic [pal_pkg::POS_W-1:0]             position  = '0;
    logic signed [pal_pkg::VAL_W-1:0]      value     = '0;
    logic                                  busy;
    logic                                  done;
    logic [pal_pkg::STAT_W-1:0]            status;
    logic signed [pal_pkg::VAL_W-1:0]      data_out;
    logic [pal_pkg::CNT_OUT_W-1:0]         count_out;

    list_op_t     pending_ops[$];
    list_resp_t   expected_results[$];
    list_state_t  list_shadow;     // list as the block should hold it, advanced on acceptance
    list_state_t  gen_shadow;      // list as the generator expects it, used to aim positions
    list_op_t     cur_op;
    list_resp_t   want_r;
    bit           launch;
    int           gen_idle_pct;
    int           n_accepted;
    int           n_returned;
    int           n_errors;
    int           cycle_count;

    positional_array_list_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .position  (position),
        .value     (value),
        .done      (done),
        .status    (status),
        .data_out  (data_out),
        .count_out (count_out)
    );

    always #CLK_HALF clk = ~clk;

    // applies one operation to a list, returns what the block should report
    function automatic list_resp_t apply_list_op(inout list_state_t st, input list_op_t item);
        list_resp_t r;
        int idx;
        r.status = pal_pkg::ST_OK;
        r.data   = '0;
        if (item.op == pal_pkg::OP_INSERT)
        begin
            if (item.pos == 0 || item.pos > st.len + 1)
            begin
                r.status = pal_pkg::ST_BADPOS;
            end
            // position check wins over the full check
            else if (st.len >= pal_pkg::CAPACITY)
            begin
                r.status = pal_pkg::ST_FULL;
            end
            else
            begin
                idx = item.pos - 1;
                for (int i = st.len; i > idx; i--)
                    st.words[i] = st.words[i-1];
                st.words[idx] = item.value;
                st.len++;
            end
        end
        else if (item.pos == 0 || item.pos > st.len)
        begin
            // also covers every access to an empty list
            r.status = pal_pkg::ST_BADPOS;
        end
        else
        begin
            idx = item.pos - 1;
            case (item.op)
                pal_pkg::OP_DELETE:
                begin
                    r.data = st.words[idx];
                    for (int i = idx; i < st.len - 1; i++)
                        st.words[i] = st.words[i+1];
                    st.len--;
                end
                pal_pkg::OP_UPDATE:
                begin
                    st.words[idx] = item.value;
                end
                default:
                begin
                    r.data = st.words[idx];
                end
            endcase
        end
        r.count = pal_pkg::CNT_OUT_W'(st.len);
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [pal_pkg::VAL_W-1:0] want,
                                 logic [pal_pkg::VAL_W-1:0] got);
        n_errors++;
        if (n_errors <= PRINT_LIMIT)
            $display("%0t: mismatch on %s, expected %h, got %h", $time, what, want, got);
    endtask

    // queues one item and advances the generator's view of the list
    task automatic queue_op(logic [pal_pkg::OP_W-1:0] op, logic [pal_pkg::POS_W-1:0] pos,
                            logic signed [pal_pkg::VAL_W-1:0] val);
        list_op_t item;
        list_resp_t ignored;
        item.op       = op;
        item.pos      = pos;
        item.value    = val;
        item.drain    = 1'b0;
        item.idle_pct = gen_idle_pct;
        ignored = apply_list_op(gen_shadow, item);
        pending_ops.push_back(item);
    endtask

    // sender holds here until every outstanding result has come back
    task automatic queue_drain();
        list_op_t item;
        item.op       = pal_pkg::OP_READ;
        item.pos      = '0;
        item.value    = '0;
        item.drain    = 1'b1;
        item.idle_pct = 0;
        pending_ops.push_back(item);
    endtask

    // mostly well-formed traffic: fill runs drive the list to full, drain runs back to empty
    task automatic queue_random_op(inout bit filling);
        logic [pal_pkg::OP_W-1:0] op;
        logic signed [pal_pkg::VAL_W-1:0] val;
        int roll;
        int limit;
        int pos;
        if (filling && gen_shadow.len == pal_pkg::CAPACITY && $urandom_range(7) == 0)
            filling = 1'b0;
        if (!filling && gen_shadow.len == 0)
            filling = 1'b1;
        roll = $urandom_range(99);
        if (filling)
            op = (roll < 60) ? pal_pkg::OP_INSERT : (roll < 72) ? pal_pkg::OP_DELETE :
                 (roll < 86) ? pal_pkg::OP_UPDATE : pal_pkg::OP_READ;
        else
            op = (roll < 15) ? pal_pkg::OP_INSERT : (roll < 65) ? pal_pkg::OP_DELETE :
                 (roll < 82) ? pal_pkg::OP_UPDATE : pal_pkg::OP_READ;
        // last legal position; an insert into a full list still aims at a legal slot
        limit = (op == pal_pkg::OP_INSERT) ? gen_shadow.len + 1 : gen_shadow.len;
        roll = $urandom_range(99);
        if (roll < 85 && limit > 0)
            pos = $urandom_range(limit, 1);
        else if (roll < 90)
            pos = 0;
        else if (roll < 95)
            pos = limit + 1;
        else
            pos = $urandom_range(63);
        case ($urandom_range(9))
            0: val = 32'sh7fffffff;
            1: val = 32'sh80000000;
            2: val = '0;
            3: val = -32'sd1;
            default: val = $urandom;
        endcase
        queue_op(op, pal_pkg::POS_W'(pos), val);
    endtask

    // driver: holds an item until taken, predicts on acceptance, then maybe idles
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            launch = 1'b0;
            if (start && busy)
            begin
                launch = 1'b1;
            end
            else
            begin
                if (start)
                begin
                    expected_results.push_back(apply_list_op(list_shadow, cur_op));
                    n_accepted++;
                end
                // n_returned is updated by nonblocking assignment, so this read is stable
                if (pending_ops.size() != 0 && pending_ops[0].drain
                    && n_accepted == n_returned)
                    void'(pending_ops.pop_front());
                if (pending_ops.size() != 0 && !pending_ops[0].drain
                    && $urandom_range(99) >= pending_ops[0].idle_pct)
                begin
                    cur_op = pending_ops.pop_front();
                    launch = 1'b1;
                    operation <= cur_op.op;
                    position  <= cur_op.pos;
                    value     <= cur_op.value;
                end
            end
            start <= launch;
        end
    end

    // monitor: every done cycle carries a result, matched in order
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            n_returned <= n_returned + 1;
            if (expected_results.size() == 0)
            begin
                flag_mismatch("result with no item outstanding", '0, data_out);
            end
            else
            begin
                want_r = expected_results.pop_front();
                if (status !== want_r.status)
                    flag_mismatch("status", pal_pkg::VAL_W'(want_r.status),
                                  pal_pkg::VAL_W'(status));
                if (data_out !== want_r.data)
                    flag_mismatch("data_out", want_r.data, data_out);
                if (count_out !== want_r.count)
                    flag_mismatch("count_out", pal_pkg::VAL_W'(want_r.count),
                                  pal_pkg::VAL_W'(count_out));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_positional_array_list_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        bit filling;
        n_accepted        = 0;
        n_returned        = 0;
        n_errors          = 0;
        cycle_count       = 0;
        gen_shadow.len    = 0;
        list_shadow.len   = 0;
        gen_idle_pct      = 25;
        filling           = 1'b1;

        // directed: empty list, both ends and the middle, out-of-range positions
        queue_op(pal_pkg::OP_READ,   6'd1,  $urandom);
        queue_op(pal_pkg::OP_DELETE, 6'd0,  $urandom);
        queue_op(pal_pkg::OP_UPDATE, 6'd1,  32'sh12345678);
        queue_op(pal_pkg::OP_INSERT, 6'd2,  32'sh0badf00d);
        queue_op(pal_pkg::OP_INSERT, 6'd0,  32'sh0badf00d);
        queue_op(pal_pkg::OP_INSERT, 6'd1,  32'sh7fffffff);
        queue_op(pal_pkg::OP_INSERT, 6'd1,  32'sh80000000);
        queue_op(pal_pkg::OP_INSERT, 6'd3,  -32'sd1);
        queue_op(pal_pkg::OP_INSERT, 6'd2,  32'sd0);
        queue_op(pal_pkg::OP_READ,   6'd1,  $urandom);
        queue_op(pal_pkg::OP_READ,   6'd4,  $urandom);
        queue_op(pal_pkg::OP_READ,   6'd5,  $urandom);
        queue_op(pal_pkg::OP_UPDATE, 6'd4,  32'sh55555555);
        queue_op(pal_pkg::OP_UPDATE, 6'd5,  32'sh2aaaaaaa);
        queue_op(pal_pkg::OP_UPDATE, 6'd63, 32'sh2aaaaaaa);
        queue_op(pal_pkg::OP_DELETE, 6'd2,  $urandom);
        queue_op(pal_pkg::OP_DELETE, 6'd3,  $urandom);
        queue_op(pal_pkg::OP_DELETE, 6'd63, $urandom);
        queue_op(pal_pkg::OP_READ,   6'd63, $urandom);
        queue_op(pal_pkg::OP_INSERT, 6'd63, 32'shaaaaaaaa);
        queue_op(pal_pkg::OP_DELETE, 6'd1,  $urandom);
        queue_op(pal_pkg::OP_DELETE, 6'd1,  $urandom);
        queue_op(pal_pkg::OP_DELETE, 6'd1,  $urandom);
        queue_op(pal_pkg::OP_INSERT, 6'd1,  32'shaaaaaaaa);
        queue_drain();

        // random: sender idles a quarter of the time, then two thirds, then never
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 3)
            begin
                queue_drain();
                gen_idle_pct = 67;
            end
            else if (n == 2 * N_RANDOM / 3)
            begin
                queue_drain();
                gen_idle_pct = 0;
            end
            queue_random_op(filling);
        end

        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;

        // sample on the falling edge, away from the driver and monitor updates
        do
            @(negedge clk);
        while (!(pending_ops.size() == 0 && !start && n_accepted == n_returned));
        repeat (TAIL_CYC) @(negedge clk);
        if (expected_results.size() != 0)
            flag_mismatch("results never returned", expected_results.size(), '0);

        if (n_errors == 0)
            $display("tb_positional_array_list_top: done, clean");
        else
            $display("tb_positional_array_list_top: done, errors");
        $finish;
    end

endmodule
